/* sv/lbfi_pkg.sv */
`timescale 1ns / 1ps
// Package: shared types, face codes and helper functions for the line/box face intersect block.
package lbfi_pkg;

   localparam int NUM_FACES = 6;
   localparam int DIV_STEPS = 34;

   localparam logic [15:0] EPS_RESET = 16'd66;

   localparam logic [2:0] FACE_FRONT = 3'd0;
   localparam logic [2:0] FACE_BACK  = 3'd1;
   localparam logic [2:0] FACE_LEFT  = 3'd2;
   localparam logic [2:0] FACE_RIGHT = 3'd3;
   localparam logic [2:0] FACE_UP    = 3'd4;
   localparam logic [2:0] FACE_DOWN  = 3'd5;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [33:0] QUO_LIMIT = 34'h2_0000_0000;

   typedef logic [2:0][31:0] vec3_type;
   typedef logic [5:0][1:0][62:0] mag_type;
   typedef logic [5:0][1:0][33:0] quo_type;

   typedef struct packed {
      vec3_type              pt;
      vec3_type              lo;
      vec3_type              hi;
      logic [5:0]            skip;
      logic [5:0][32:0]      n;
      logic [5:0][31:0]      ad;
      logic [5:0][1:0]       neg;
   } side_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  face;
      vec3_type    p;
      logic [32:0] n;
      logic [31:0] ad;
   } cand_type;

   typedef cand_type [5:0] cands_type;

   function automatic logic [1:0] face_axis(input logic [2:0] f);
      logic [1:0] a;
      case (f)
         FACE_FRONT, FACE_BACK: a = AXIS_Z;
         FACE_LEFT, FACE_RIGHT: a = AXIS_X;
         default:               a = AXIS_Y;
      endcase
      return a;
   endfunction

   function automatic logic face_upper(input logic [2:0] f);
      return (f == FACE_FRONT) || (f == FACE_RIGHT) || (f == FACE_UP);
   endfunction

   function automatic logic [1:0] off_axis(input logic [1:0] a, input logic j);
      logic [1:0] k;
      case (a)
         AXIS_X:  k = j ? AXIS_Z : AXIS_Y;
         AXIS_Y:  k = j ? AXIS_X : AXIS_Z;
         default: k = j ? AXIS_Y : AXIS_X;
      endcase
      return k;
   endfunction

   // later hit candidate wins when the earlier one misses or on a strictly larger t
   function automatic cand_type pick(input cand_type a, input cand_type b, input logic gt);
      return (b.hit && (!a.hit || gt)) ? b : a;
   endfunction

endpackage

/* sv/lbfi_if.sv */
`timescale 1ns / 1ps
// Interfaces: request, response and register write channels.
interface lbfi_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] line_point_x;
   logic [31:0] line_point_y;
   logic [31:0] line_point_z;
   logic [31:0] direction_x;
   logic [31:0] direction_y;
   logic [31:0] direction_z;
   logic [31:0] box_min_x;
   logic [31:0] box_min_y;
   logic [31:0] box_min_z;
   logic [31:0] box_max_x;
   logic [31:0] box_max_y;
   logic [31:0] box_max_z;
   modport source (output valid, line_point_x, line_point_y, line_point_z,
                   direction_x, direction_y, direction_z, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, input ready);
   modport sink (input valid, line_point_x, line_point_y, line_point_z,
                 direction_x, direction_y, direction_z, box_min_x, box_min_y, box_min_z,
                 box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface lbfi_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [2:0]  face;
   logic [31:0] point_x;
   logic [31:0] point_y;
   logic [31:0] point_z;
   modport source (output valid, hit, face, point_x, point_y, point_z, input ready);
   modport sink (input valid, hit, face, point_x, point_y, point_z, output ready);
endinterface

interface lbfi_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* sv/lbfi_front.sv */
`timescale 1ns / 1ps
// Front stages: input register, face setup, numerator products, magnitude and sign.
module lbfi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_v,
   input  lbfi_pkg::vec3_type pt,
   input  lbfi_pkg::vec3_type dir,
   input  lbfi_pkg::vec3_type lo,
   input  lbfi_pkg::vec3_type hi,
   input  logic [15:0]       eps,
   output logic              out_v,
   output lbfi_pkg::side_type side,
   output lbfi_pkg::mag_type mag
);
   import lbfi_pkg::*;

   logic [3:0] v_ff;
   vec3_type pt0_ff, dir0_ff, lo0_ff, hi0_ff, dir1_ff;
   side_type s1_ff, s1_in, s2_ff, s3_ff, s3_in;
   logic [5:0][1:0][63:0] prod_ff, prod_in;
   mag_type mag_ff, mag_in;

   always_comb begin
      logic [1:0] a;
      logic signed [31:0] d;
      logic [31:0] plane;
      logic signed [32:0] nn;
      s1_in = '0;
      s1_in.pt = pt0_ff;
      s1_in.lo = lo0_ff;
      s1_in.hi = hi0_ff;
      for (int f = 0; f < NUM_FACES; f++) begin
         a = face_axis(3'(f));
         d = $signed(dir0_ff[a]);
         plane = face_upper(3'(f)) ? hi0_ff[a] : lo0_ff[a];
         nn = $signed({plane[31], plane}) - $signed({pt0_ff[a][31], pt0_ff[a]});
         if (d[31]) nn = -nn;
         s1_in.n[f] = nn;
         s1_in.ad[f] = d[31] ? (~dir0_ff[a] + 32'd1) : dir0_ff[a];
         s1_in.skip[f] = (d == 32'sd0) || (s1_in.ad[f] < {16'd0, eps});
      end
   end

   always_comb begin
      logic signed [64:0] pr;
      logic signed [32:0] nf;
      logic signed [31:0] df;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int j = 0; j < 2; j++) begin
            nf = $signed(s1_ff.n[f]);
            df = $signed(dir1_ff[off_axis(face_axis(3'(f)), j[0])]);
            pr = nf * df;
            prod_in[f][j] = pr[63:0];
         end
      end
   end

   always_comb begin
      logic [63:0] m;
      s3_in = s2_ff;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int j = 0; j < 2; j++) begin
            s3_in.neg[f][j] = prod_ff[f][j][63];
            m = prod_ff[f][j][63] ? (~prod_ff[f][j] + 64'd1) : prod_ff[f][j];
            mag_in[f][j] = m[62:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt0_ff  <= pt;
         dir0_ff <= dir;
         lo0_ff  <= lo;
         hi0_ff  <= hi;
         s1_ff   <= s1_in;
         dir1_ff <= dir0_ff;
         prod_ff <= prod_in;
         s2_ff   <= s1_ff;
         s3_ff   <= s3_in;
         mag_ff  <= mag_in;
      end
   end

   assign out_v = v_ff[3];
   assign side  = s3_ff;
   assign mag   = mag_ff;

endmodule

/* sv/lbfi_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider lane, one quotient bit per stage, top bit flags overflow.
module lbfi_div (
   input  logic        clock,
   input  logic        en,
   input  logic [62:0] num,
   input  logic [31:0] den,
   output logic [33:0] quo
);
   import lbfi_pkg::*;

   logic [62:0] rem_ff [DIV_STEPS];
   logic [62:0] rem_in [DIV_STEPS];
   logic [31:0] den_ff [DIV_STEPS];
   logic [31:0] den_in [DIV_STEPS];
   logic [33:0] q_ff   [DIV_STEPS];
   logic [33:0] q_in   [DIV_STEPS];

   always_comb begin
      logic [62:0] r;
      logic [31:0] dv;
      logic [33:0] q;
      logic [64:0] sh;
      logic [64:0] diff;
      for (int st = 0; st < DIV_STEPS; st++) begin
         r  = (st == 0) ? num : rem_ff[(st == 0) ? 0 : st - 1];
         dv = (st == 0) ? den : den_ff[(st == 0) ? 0 : st - 1];
         q  = (st == 0) ? 34'd0 : q_ff[(st == 0) ? 0 : st - 1];
         sh = {33'd0, dv} << (DIV_STEPS - 1 - st);
         diff = {2'b00, r} - sh;
         if ({2'b00, r} >= sh) begin
            r = diff[62:0];
            q[DIV_STEPS - 1 - st] = 1'b1;
         end
         rem_in[st] = r;
         den_in[st] = dv;
         q_in[st]   = q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int st = 0; st < DIV_STEPS; st++) begin
            rem_ff[st] <= rem_in[st];
            den_ff[st] <= den_in[st];
            q_ff[st]   <= q_in[st];
         end
      end
   end

   assign quo = q_ff[DIV_STEPS - 1];

endmodule

/* sv/lbfi_test.sv */
`timescale 1ns / 1ps
// Back stages: signed quotient add, saturation and bound test, per-face candidate build.
module lbfi_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_v,
   input  lbfi_pkg::side_type side,
   input  lbfi_pkg::quo_type  quo,
   input  logic [15:0]        eps,
   output logic               out_v,
   output lbfi_pkg::cands_type cand
);
   import lbfi_pkg::*;

   logic [2:0] v_ff;
   side_type t1_ff, t2_ff;
   logic [5:0][1:0][35:0] sum_ff, sum_in;
   logic [5:0][1:0][31:0] p_ff, p_in;
   logic [5:0][1:0] inb_ff, inb_in;
   cands_type cand_ff, cand_in;

   always_comb begin
      logic [33:0] qc;
      logic [35:0] qs;
      logic [1:0] k;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int j = 0; j < 2; j++) begin
            k  = off_axis(face_axis(3'(f)), j[0]);
            qc = quo[f][j][33] ? QUO_LIMIT : quo[f][j];
            qs = {2'b00, qc};
            if (side.neg[f][j]) qs = ~qs + 36'd1;
            sum_in[f][j] = {{4{side.pt[k][31]}}, side.pt[k]} + qs;
         end
      end
   end

   always_comb begin
      logic [35:0] s;
      logic [31:0] p;
      logic signed [33:0] pe, blo, bhi;
      logic [1:0] k;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int j = 0; j < 2; j++) begin
            k = off_axis(face_axis(3'(f)), j[0]);
            s = sum_ff[f][j];
            if ((s[35:31] == 5'b00000) || (s[35:31] == 5'b11111)) begin
               p = s[31:0];
            end else begin
               p = s[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            pe  = $signed({{2{p[31]}}, p});
            blo = $signed({{2{t1_ff.lo[k][31]}}, t1_ff.lo[k]}) - $signed({18'd0, eps});
            bhi = $signed({{2{t1_ff.hi[k][31]}}, t1_ff.hi[k]}) + $signed({18'd0, eps});
            p_in[f][j]   = p;
            inb_in[f][j] = (pe > blo) && (pe < bhi);
         end
      end
   end

   always_comb begin
      logic [1:0] a;
      for (int f = 0; f < NUM_FACES; f++) begin
         a = face_axis(3'(f));
         cand_in[f].hit  = !t2_ff.skip[f] && (eps != 16'd0) && (&inb_ff[f]);
         cand_in[f].face = 3'(f);
         cand_in[f].n    = t2_ff.n[f];
         cand_in[f].ad   = t2_ff.ad[f];
         cand_in[f].p    = '0;
         cand_in[f].p[a] = face_upper(3'(f)) ? t2_ff.hi[a] : t2_ff.lo[a];
         cand_in[f].p[off_axis(a, 1'b0)] = p_ff[f][0];
         cand_in[f].p[off_axis(a, 1'b1)] = p_ff[f][1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= side;
         sum_ff  <= sum_in;
         t2_ff   <= t1_ff;
         p_ff    <= p_in;
         inb_ff  <= inb_in;
         cand_ff <= cand_in;
      end
   end

   assign out_v = v_ff[2];
   assign cand  = cand_ff;

endmodule

/* sv/lbfi_select.sv */
`timescale 1ns / 1ps
// Selection tree: largest t among hit faces, cross-multiplied compare, earlier face on ties.
module lbfi_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_v,
   input  lbfi_pkg::cands_type cand,
   output logic                out_v,
   output lbfi_pkg::cand_type  best
);
   import lbfi_pkg::*;

   logic [5:0] v_ff;
   cands_type c1_ff;
   cand_type [2:0] w1_ff, c2_ff;
   cand_type [1:0] w2_ff, c3_ff;
   cand_type best_ff;
   logic signed [65:0] pa1_ff [3];
   logic signed [65:0] pb1_ff [3];
   logic signed [65:0] pa2_ff, pb2_ff, pa3_ff, pb3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= cand;
         for (int pr = 0; pr < 3; pr++) begin
            pb1_ff[pr] <= $signed(cand[2*pr+1].n) * $signed({1'b0, cand[2*pr].ad});
            pa1_ff[pr] <= $signed(cand[2*pr].n) * $signed({1'b0, cand[2*pr+1].ad});
            w1_ff[pr]  <= pick(c1_ff[2*pr], c1_ff[2*pr+1], pb1_ff[pr] > pa1_ff[pr]);
         end
         c2_ff    <= w1_ff;
         pb2_ff   <= $signed(w1_ff[1].n) * $signed({1'b0, w1_ff[0].ad});
         pa2_ff   <= $signed(w1_ff[0].n) * $signed({1'b0, w1_ff[1].ad});
         w2_ff[0] <= pick(c2_ff[0], c2_ff[1], pb2_ff > pa2_ff);
         w2_ff[1] <= c2_ff[2];
         c3_ff    <= w2_ff;
         pb3_ff   <= $signed(w2_ff[1].n) * $signed({1'b0, w2_ff[0].ad});
         pa3_ff   <= $signed(w2_ff[0].n) * $signed({1'b0, w2_ff[1].ad});
         best_ff  <= pick(c3_ff[0], c3_ff[1], pb3_ff > pa3_ff);
      end
   end

   assign out_v = v_ff[5];
   assign best  = best_ff;

endmodule

/* sv/line_box_face_intersect_top.sv */
`timescale 1ns / 1ps
// Top level: line against axis-aligned box, nearest-by-largest-t face hit.
//
// req_bus carries one line (point, direction) and one box per beat, signed Q16.16.
// rsp_bus returns one beat per request: hit flag, face code and intersection point;
// a miss returns all zero fields. csr_bus writes the 16-bit epsilon register,
// ready outside reset; write it only while no request is in flight.
// A request beat passes through 48 register stages on its way to rsp_bus,
// the output register included, the first loaded at the request edge.
// Throughput is one beat per cycle when not stalled; the depth is set by the 34-stage
// quotient pipelines, one per face and off-face axis, twelve lanes in all.
// Reset clears all valid bits and loads epsilon with 66; req_bus.ready and
// csr_bus.ready stay low during reset, so no request is lost.
// When the receiver stalls, the held response stays stable and the pipeline keeps
// moving as long as the stage ahead of the output register is empty; once that
// stage holds a beat, the whole pipeline and req_bus.ready hold until rsp_bus.ready.
module line_box_face_intersect_top (
   input logic        clock,
   input logic        reset,
   lbfi_req_if.sink   req_bus,
   lbfi_rsp_if.source rsp_bus,
   lbfi_csr_if.sink   csr_bus
);
   import lbfi_pkg::*;

   logic [15:0] eps_ff;
   logic adv, ld;
   logic front_v, test_v, sel_v;
   side_type front_side;
   mag_type mag;
   quo_type quo;
   side_type side_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_ff;
   cands_type cand;
   cand_type best;
   vec3_type pt, dir, lo, hi;
   logic rsp_v_ff, hit_ff;
   logic [2:0] face_ff;
   vec3_type point_ff;

   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_bus.valid) begin
         eps_ff <= csr_bus.data;
      end
   end

   assign ld  = !rsp_v_ff || rsp_bus.ready;
   assign adv = ld || !sel_v;
   assign req_bus.ready = adv && !reset;

   assign pt  = {req_bus.line_point_z, req_bus.line_point_y, req_bus.line_point_x};
   assign dir = {req_bus.direction_z, req_bus.direction_y, req_bus.direction_x};
   assign lo  = {req_bus.box_min_z, req_bus.box_min_y, req_bus.box_min_x};
   assign hi  = {req_bus.box_max_z, req_bus.box_max_y, req_bus.box_max_x};

   lbfi_front u_front (
      .clock (clock), .reset (reset), .en (adv), .in_v (req_bus.valid),
      .pt (pt), .dir (dir), .lo (lo), .hi (hi), .eps (eps_ff),
      .out_v (front_v), .side (front_side), .mag (mag)
   );

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      for (genvar j = 0; j < 2; j++) begin : g_lane
         lbfi_div u_div (
            .clock (clock), .en (adv), .num (mag[f][j]),
            .den (front_side.ad[f]), .quo (quo[f][j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[DIV_STEPS-2:0], front_v};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= front_side;
         for (int st = 1; st < DIV_STEPS; st++) begin
            side_ff[st] <= side_ff[st-1];
         end
      end
   end

   lbfi_test u_test (
      .clock (clock), .reset (reset), .en (adv), .in_v (dv_ff[DIV_STEPS-1]),
      .side (side_ff[DIV_STEPS-1]), .quo (quo), .eps (eps_ff),
      .out_v (test_v), .cand (cand)
   );

   lbfi_select u_select (
      .clock (clock), .reset (reset), .en (adv), .in_v (test_v), .cand (cand),
      .out_v (sel_v), .best (best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (ld) begin
         rsp_v_ff <= sel_v;
      end
   end

   always_ff @(posedge clock) begin
      if (ld && sel_v) begin
         hit_ff   <= best.hit;
         face_ff  <= best.hit ? best.face : FACE_FRONT;
         point_ff <= best.hit ? best.p : '0;
      end
   end

   assign rsp_bus.valid   = rsp_v_ff;
   assign rsp_bus.hit     = hit_ff;
   assign rsp_bus.face    = face_ff;
   assign rsp_bus.point_x = point_ff[AXIS_X];
   assign rsp_bus.point_y = point_ff[AXIS_Y];
   assign rsp_bus.point_z = point_ff[AXIS_Z];

   ap_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |-> rsp_bus.face == FACE_FRONT &&
      rsp_bus.point_x == 32'd0 && rsp_bus.point_y == 32'd0 && rsp_bus.point_z == 32'd0)
      else $error("miss beat with nonzero payload");

   ap_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.hit |-> rsp_bus.face <= FACE_DOWN)
      else $error("hit beat with bad face code");

   ap_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !sel_v |-> req_bus.ready)
      else $error("request stalled with empty pre-output stage");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Testbench: line/box face intersect block checked beat by beat against a local predictor.
module testbench;
   import lbfi_pkg::*;

   localparam int LATENCY = 48;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [2:0][31:0] pt;
      logic [2:0][31:0] dir;
      logic [2:0][31:0] lo;
      logic [2:0][31:0] hi;
   } line_box_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  face;
      logic [2:0][31:0] p;
   } face_hit_type;

   typedef struct {
      line_box_type  lb;
      logic          known;
      face_hit_type  want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   lbfi_req_if req_bus();
   lbfi_rsp_if rsp_bus();
   lbfi_csr_if csr_bus();

   line_box_face_intersect_top uut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   logic [15:0]  epsilon = EPS_RESET;
   face_hit_type hits_due[$];
   int           errors = 0;
   int           hits_seen = 0;
   int           beats_out = 0;
   int           beats_in = 0;
   int           send_idle = 0;
   int           recv_stall = 0;
   logic         holding = 0;
   event         hold_go;
   longint       cycles = 0;

   // largest-t face hit for one line/box beat
   function automatic face_hit_type nearest_face(line_box_type lb, logic [15:0] eps_v);
      face_hit_type r;
      longint pt[3], dir[3], lo[3], hi[3];
      longint eps, best_n, best_d, d, ad, plane, n, q, blo, bhi;
      longint p[3];
      logic in_box, found;
      int a;
      logic up;
      r = '0;
      found = 0;
      best_n = 0;
      best_d = 1;
      eps = longint'(eps_v);
      for (int k = 0; k < 3; k++) begin
         pt[k] = longint'($signed(lb.pt[k]));
         dir[k] = longint'($signed(lb.dir[k]));
         lo[k] = longint'($signed(lb.lo[k]));
         hi[k] = longint'($signed(lb.hi[k]));
      end
      for (int f = 0; f < NUM_FACES; f++) begin
         a = (f < 2) ? 2 : (f < 4) ? 0 : 1;
         up = (f == FACE_FRONT) || (f == FACE_RIGHT) || (f == FACE_UP);
         d = dir[a];
         ad = d < 0 ? -d : d;
         if (d == 0 || ad < eps) continue;
         plane = up ? hi[a] : lo[a];
         n = plane - pt[a];
         if (d < 0) n = -n;
         in_box = 1;
         for (int k = 0; k < 3; k++) begin
            q = (n * dir[k]) / ad;
            if (q > (64'sd1 <<< 33)) q = 64'sd1 <<< 33;
            if (q < -(64'sd1 <<< 33)) q = -(64'sd1 <<< 33);
            p[k] = pt[k] + q;
            if (p[k] > 64'sd2147483647) p[k] = 64'sd2147483647;
            if (p[k] < -64'sd2147483648) p[k] = -64'sd2147483648;
            blo = (k == a ? plane : lo[k]) - eps;
            bhi = (k == a ? plane : hi[k]) + eps;
            if (!(p[k] > blo && p[k] < bhi)) in_box = 0;
         end
         if (!in_box) continue;
         if (!found || n * best_d > best_n * ad) begin
            found = 1;
            best_n = n;
            best_d = ad;
            r.hit = 1;
            r.face = f[2:0];
            for (int k = 0; k < 3; k++) r.p[k] = p[k][31:0];
         end
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch beat %0d %s: got %0h want %0h", beats_out, what, got, want);
   endtask

   // response side: checking
   always @(posedge clock) begin
      face_hit_type w;
      cycles <= cycles + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (hits_due.size() == 0) begin
            report("unexpected", 32'd0, 32'd0);
         end else begin
            w = hits_due.pop_front();
            if (rsp_bus.hit !== w.hit) report("hit", 32'(rsp_bus.hit), 32'(w.hit));
            if (rsp_bus.face !== w.face) report("face", 32'(rsp_bus.face), 32'(w.face));
            if (rsp_bus.point_x !== w.p[0]) report("point_x", rsp_bus.point_x, w.p[0]);
            if (rsp_bus.point_y !== w.p[1]) report("point_y", rsp_bus.point_y, w.p[1]);
            if (rsp_bus.point_z !== w.p[2]) report("point_z", rsp_bus.point_z, w.p[2]);
            if (w.hit) hits_seen++;
         end
         beats_out++;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_go);
         holding = 1;
         repeat (HOLD_CYCLES) @(negedge clock);
         holding = 0;
      end
   end

   always @(negedge clock) begin
      if (holding) begin
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send(line_box_type lb, logic known, face_hit_type want);
      face_hit_type pred;
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid <= 1;
      {req_bus.line_point_x, req_bus.line_point_y, req_bus.line_point_z} <=
         {lb.pt[0], lb.pt[1], lb.pt[2]};
      {req_bus.direction_x, req_bus.direction_y, req_bus.direction_z} <=
         {lb.dir[0], lb.dir[1], lb.dir[2]};
      {req_bus.box_min_x, req_bus.box_min_y, req_bus.box_min_z} <=
         {lb.lo[0], lb.lo[1], lb.lo[2]};
      {req_bus.box_max_x, req_bus.box_max_y, req_bus.box_max_z} <=
         {lb.hi[0], lb.hi[1], lb.hi[2]};
      do @(posedge clock); while (!req_bus.ready);
      pred = nearest_face(lb, epsilon);
      if (known && pred !== want)
         report("table row", 32'({pred.hit, pred.face}), 32'({want.hit, want.face}));
      hits_due = {hits_due, pred};
      beats_in++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (hits_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_epsilon(logic [15:0] v);
      csr_bus.valid <= 1;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      epsilon = v;
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $signed($urandom_range(40 << 16)) - (20 << 16);
      endcase
   endfunction

   // mostly well-formed: box with min <= max, point often midway between min and max
   function automatic line_box_type rnd_line_box();
      line_box_type lb;
      logic [31:0] x, y;
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(9) == 0) begin
            lb.lo[k] = rnd_coord();
            lb.hi[k] = rnd_coord();
            lb.pt[k] = rnd_coord();
            lb.dir[k] = $urandom_range(3) == 0 ? $urandom() : $urandom_range(4) - 2;
         end else begin
            x = rnd_coord(); y = rnd_coord();
            if ($urandom_range(3) == 0) begin x = $urandom(); y = $urandom(); end
            if ($signed(x) > $signed(y)) begin lb.lo[k] = y; lb.hi[k] = x; end
            else begin lb.lo[k] = x; lb.hi[k] = y; end
            lb.pt[k] = $urandom_range(1) ? rnd_coord()
                       : ($signed(lb.lo[k]) >>> 1) + ($signed(lb.hi[k]) >>> 1);
            case ($urandom_range(4))
               0: lb.dir[k] = 0;
               1: lb.dir[k] = $urandom();
               default: lb.dir[k] = $signed($urandom_range(8 << 16)) - (4 << 16);
            endcase
         end
      end
      return lb;
   endfunction

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;

   row_type rows[$];

   function automatic row_type mk(logic [31:0] px, py, pz, dx, dy, dz,
                                  lx, ly, lz, hx, hy, hz, logic known, face_hit_type want);
      row_type r;
      r.lb.pt = {pz, py, px};
      r.lb.dir = {dz, dy, dx};
      r.lb.lo = {lz, ly, lx};
      r.lb.hi = {hz, hy, hx};
      r.known = known;
      r.want = want;
      return r;
   endfunction

   task automatic add_row(row_type r);
      rows = {rows, r};
   endtask

   initial begin
      face_hit_type none, fr;
      line_box_type lb;
      int sel;
      none = '0;
      fr = '0; fr.hit = 1; fr.face = FACE_FRONT; fr.p = {ONE, 32'd0, 32'd0};
      req_bus.valid = 0;
      {req_bus.line_point_x, req_bus.line_point_y, req_bus.line_point_z} = '0;
      {req_bus.direction_x, req_bus.direction_y, req_bus.direction_z} = '0;
      {req_bus.box_min_x, req_bus.box_min_y, req_bus.box_min_z} = '0;
      {req_bus.box_max_x, req_bus.box_max_y, req_bus.box_max_z} = '0;
      csr_bus.valid = 0;
      csr_bus.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // unit box, lines along each axis, extremes, zero direction, equal t
      add_row(mk(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b1, none));
      add_row(mk(0, 0, 0, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b1, fr));
      add_row(mk(0, 0, 0, 0, 0, -ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, 0, -ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, 32'd65, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(0, 0, 0, 32'd66, 32'd1, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, none));
      add_row(mk(MAXV, MINV, MAXV, MINV, MAXV, MINV,
                 MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b0, none));
      add_row(mk(MINV, MAXV, MINV, MAXV, MINV, MAXV,
                 MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b0, none));
      add_row(mk(0, 0, MINV, 1, 1, MAXV, ONE, ONE, ONE, -ONE, -ONE, -ONE, 1'b0, none));
      add_row(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
                 MAXV, MAXV, MAXV, MINV, MINV, MINV, 1'b0, none));
      add_row(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                 32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 0, 0, 1'b0, none));
      add_row(mk(0, 0, 0, ONE, 32'd3, MINV, 0, 0, 0, 32'h55555555,
                 32'haaaaaaaa, 32'h55555555, 1'b0, none));
      foreach (rows[i]) send(rows[i].lb, rows[i].known, rows[i].want);
      drain();

      // zero epsilon: never a hit
      write_epsilon(16'd0);
      send(rows[1].lb, 1'b1, none);
      send(rows[7].lb, 1'b1, none);
      for (int i = 0; i < 5; i++) send(rnd_line_box(), 1'b0, none);
      drain();
      write_epsilon(16'hffff);
      foreach (rows[i]) send(rows[i].lb, 1'b0, none);
      drain();

      // random phases across idling patterns and epsilon settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 74; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 74; end
            3: begin send_idle = 29; recv_stall = 29; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         if (ph == 4) -> hold_go;
         sel = $urandom_range(3);
         write_epsilon(16'(sel == 0 ? 16'd66 : sel == 1 ? 16'hffff : sel == 2 ? 16'd1
                           : $urandom_range(16'hffff)));
         for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
            lb = rnd_line_box();
            send(lb, 1'b0, none);
         end
         drain();
      end

      $display("covered %0d beats in, %0d out, %0d hits, epsilon incl. 0 and 65535",
               beats_in, beats_out, hits_seen);
      if (errors == 0 && hits_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

/* files.f */
sv/lbfi_pkg.sv
sv/lbfi_if.sv
sv/lbfi_front.sv
sv/lbfi_div.sv
sv/lbfi_test.sv
sv/lbfi_select.sv
sv/line_box_face_intersect_top.sv
test/testbench.sv
